>>> rtl/swsfd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the single-wire sensor frame decoder.
package swsfd_pkg;

    localparam int TIME_W   = 16;
    localparam int THR_W    = 16;
    localparam int LEAD_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int SHIFT_W  = 40;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BIT_THRESHOLD  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEAD_INTERVALS = 1'd1;

    localparam logic [THR_W-1:0]  THRESHOLD_RESET = 16'd110;
    localparam logic [LEAD_W-1:0] LEAD_RESET      = 2'd0;

    typedef struct packed {
        logic [TIME_W-1:0] capture_time;
    } t_capture;

    typedef struct packed {
        logic [BYTE_W-1:0] humidity_int;
        logic [BYTE_W-1:0] humidity_frac;
        logic [BYTE_W-1:0] temperature_int;
        logic [BYTE_W-1:0] temperature_frac;
        logic [BYTE_W-1:0] checksum_byte;
        logic              data_ok;
    } t_result;

endpackage

>>> rtl/swsfd_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interface carrying one payload word per handshake.
interface swsfd_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/swsfd_frame_check.sv
`timescale 1ns / 1ps
// Splits a received frame into its five bytes and checks the checksum.
module swsfd_frame_check
    import swsfd_pkg::*;
(
    input  logic [SHIFT_W-1:0] i_frame,
    output t_result            o_result
);
    logic [BYTE_W-1:0] sum;

    always_comb begin
        o_result.humidity_int     = i_frame[39:32];
        o_result.humidity_frac    = i_frame[31:24];
        o_result.temperature_int  = i_frame[23:16];
        o_result.temperature_frac = i_frame[15:8];
        o_result.checksum_byte    = i_frame[7:0];
        // mod-256 sum wraps naturally in the byte-wide adder
        sum = i_frame[39:32] + i_frame[31:24] + i_frame[23:16] + i_frame[15:8];
        o_result.data_ok = (sum == i_frame[7:0]);
    end
endmodule

>>> rtl/single_wire_sensor_frame_decoder.sv
`timescale 1ns / 1ps
// Top level of the single-wire sensor frame decoder.
// A result word reaches o_res through the input register, then the result
//   register, after the capture word that completes its frame is accepted.
// Throughput: one capture word per cycle, except while a finished frame
//   waits on a stalled result; update: 16-bit subtract, compare and shift.
// Reset (synchronous, active low) clears the edge counter, both valid flags
//   and loads the registers with threshold 110 and zero lead intervals.
module single_wire_sensor_frame_decoder
    import swsfd_pkg::*;
#(
    parameter int FRAME_BITS = 40
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    swsfd_stream_if.sink          i_cap,
    swsfd_stream_if.source        o_res
);
    // Counter holds edge numbers up to FRAME_BITS plus the largest lead count.
    localparam int CNT_W = $clog2(FRAME_BITS + 4);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(FRAME_BITS + 3);

    // Configuration registers.
    logic [THR_W-1:0]  r_thr;
    logic [LEAD_W-1:0] r_lead;

    // Input register stage.
    logic              r_in_valid;
    logic [TIME_W-1:0] r_in_time;

    // Frame state.
    logic [TIME_W-1:0]  r_prev, n_prev;
    logic [CNT_W-1:0]   r_edge_cnt, n_edge_cnt;
    logic [SHIFT_W-1:0] r_shift, n_shift;

    // Result register.
    logic    r_out_valid;
    t_result r_out;

    logic [TIME_W-1:0]  interval;
    logic               data_bit;
    logic [SHIFT_W-1:0] frame_word;
    logic               frame_done;
    logic               s_go;
    t_result            frame_res;

    function automatic logic [TIME_W-1:0] i_cap_time_sub(
        input logic [TIME_W-1:0] a,
        input logic [TIME_W-1:0] b
    );
        return a - b;
    endfunction

    // Write configuration; bits above each register's width are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= THRESHOLD_RESET;
            r_lead <= LEAD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BIT_THRESHOLD:  r_thr  <= i_cfg_wdata[THR_W-1:0];
                REG_LEAD_INTERVALS: r_lead <= i_cfg_wdata[LEAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Edge-to-edge interval, modulo 2^16, so a timer wrap is harmless.
    assign interval = i_cap_time_sub(r_in_time, r_prev);
    assign data_bit = (interval >= r_thr);

    // Next frame state for the word held in the input register.
    always_comb begin
        n_prev     = r_in_time;
        n_edge_cnt = r_edge_cnt;
        frame_word = r_shift;
        frame_done = 1'b0;
        if (r_edge_cnt == '0) begin
            // First edge of a frame: record its time, start clean.
            n_edge_cnt = CNT_W'(1);
            frame_word = '0;
        end else begin
            // Past the lead intervals, shift the decoded bit in MSB first.
            if (r_edge_cnt > CNT_W'(r_lead)) begin
                frame_word = {r_shift[SHIFT_W-2:0], data_bit};
            end
            if (r_edge_cnt < CNT_W'(r_lead) + CNT_W'(FRAME_BITS)) begin
                n_edge_cnt = r_edge_cnt + CNT_W'(1);
            end else begin
                frame_done = 1'b1;
                n_edge_cnt = '0;
            end
        end
        n_shift = frame_done ? '0 : frame_word;
    end

    swsfd_frame_check u_frame_check (
        .i_frame  (frame_word),
        .o_result (frame_res)
    );

    // Advance the held word unless it finishes a frame while the result
    // register is still full and stalled.
    assign s_go        = r_in_valid && (!frame_done || !r_out_valid || o_res.ready);
    assign i_cap.ready = !r_in_valid || s_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cap.ready) begin
            r_in_valid <= i_cap.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cap.ready && i_cap.valid) begin
            r_in_time <= i_cap.data.capture_time;
        end
    end

    // Frame state: only the counter needs reset, the rest is loaded at the
    // first edge of every frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_cnt <= '0;
        end else if (s_go) begin
            r_edge_cnt <= n_edge_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_go) begin
            r_prev  <= n_prev;
            r_shift <= n_shift;
        end
    end

    // Result register: hold until taken, load when a frame completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_go && frame_done) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_go && frame_done) begin
            r_out <= frame_res;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // Edge counter never runs past the last edge of the longest frame.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edge_cnt <= CNT_MAX)
        else $error("edge counter out of range");

    // A completed frame shows a result and restarts the counter.
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_go && frame_done |=> r_out_valid && (r_edge_cnt == '0))
        else $error("frame completion did not issue a result or restart");

    // A new result appears only after a word left the input register.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid) && ($past(r_edge_cnt) != '0))
        else $error("result appeared without a completing word");

    // A stalled result is never overwritten by a later frame.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_res.ready |-> !(s_go && frame_done))
        else $error("pending result overwritten");

endmodule
